// ===== hdl/huffman_code_bit_packer_defines.svh =====
// Assertion macros for the code bit packer checker.
// No dependencies; included by the checker file only.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// same-cycle implication, masked during reset
`define HCBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define HCBP_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/hcbp_pkg.sv =====
// Shared types and constants for the code bit packer.
// No dependencies.
`timescale 1ns / 1ps

package hcbp_pkg;

   localparam int SYMBOL_BITS      = 8;
   localparam int CODE_BITS        = 16;
   localparam int LEN_BITS         = 5;
   localparam int BYTE_BITS        = 8;
   localparam int TAIL_BITS        = 3;
   localparam int PEND_BITS        = 7;
   localparam int ACC_BITS         = PEND_BITS + CODE_BITS;
   localparam int TOTAL_BITS       = 5;
   localparam int REQ_DATA_W       = 32;
   localparam int REQ_USER_W       = 2;
   localparam int RSP_DATA_W       = 16;
   localparam int FIFO_DEPTH       = 4;
   localparam int PTR_W            = $clog2(FIFO_DEPTH);
   localparam int CNT_W            = PTR_W + 1;
   localparam int DEF_MAX_CODE_LEN = 16;
   localparam int DEF_SYMBOL_COUNT = 256;

   localparam logic [REQ_USER_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [REQ_USER_W-1:0] REQ_ENCODE = 2'd1;
   localparam logic [REQ_USER_W-1:0] REQ_FLUSH  = 2'd2;

   typedef struct packed {
      logic                 hit;
      logic [CODE_BITS-1:0] code;
      logic [LEN_BITS-1:0]  len;
   } entry_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 byte_valid;
      logic [TAIL_BITS-1:0] tail_bits;
      logic                 last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type r0;
      rsp_item_type r1;
   } push_type;

endpackage

// ===== hdl/hcbp_code_table.sv =====
// Code table memory with per-entry valid bits and load-side saturation.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_code_table #(
   parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load_en,
   input  logic                             encode_en,
   input  logic [hcbp_pkg::SYMBOL_BITS-1:0] symbol,
   input  logic [hcbp_pkg::CODE_BITS-1:0]   code_bits,
   input  logic [hcbp_pkg::LEN_BITS-1:0]    code_len,
   output hcbp_pkg::entry_type              entry
);
   import hcbp_pkg::*;

   localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
   localparam int EFF_MAX = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
   localparam logic [LEN_BITS-1:0] EFF_LEN = LEN_BITS'(EFF_MAX);

   logic [CODE_BITS+LEN_BITS-1:0] mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0]       valid_ff;
   logic [CODE_BITS+LEN_BITS-1:0] rd_ff;
   logic                          hit_ff;

   logic                 in_range;
   logic [ADDR_W-1:0]    addr;
   logic [LEN_BITS-1:0]  len_sat;
   logic [CODE_BITS:0]   mask;
   logic [CODE_BITS-1:0] code_mask;

   assign in_range  = {1'b0, symbol} < (SYMBOL_BITS + 1)'(SYMBOL_COUNT);
   assign addr      = symbol[ADDR_W-1:0];
   assign len_sat   = (code_len > EFF_LEN) ? EFF_LEN : code_len;
   assign mask      = ((CODE_BITS + 1)'(1) << len_sat) - (CODE_BITS + 1)'(1);
   assign code_mask = code_bits & mask[CODE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (load_en && in_range) begin
         mem[addr] <= {code_mask, len_sat};
      end
      if (encode_en) begin
         rd_ff  <= mem[addr];
         hit_ff <= in_range && valid_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (load_en && in_range) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   assign entry.hit  = hit_ff;
   assign entry.code = rd_ff[CODE_BITS+LEN_BITS-1:LEN_BITS];
   assign entry.len  = rd_ff[LEN_BITS-1:0];

endmodule

// ===== hdl/hcbp_pack.sv =====
// Packing stage: holds the bit buffer, appends codes and cuts out bytes.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_pack (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic                take_flush,
   input  hcbp_pkg::entry_type entry,
   input  logic                space,
   output logic                take_ready,
   output hcbp_pkg::push_type  push
);
   import hcbp_pkg::*;

   logic                  s1_valid_ff;
   logic                  s1_flush_ff;
   logic [PEND_BITS-1:0]  pbits_ff, pbits_in;
   logic [TAIL_BITS-1:0]  pcount_ff, pcount_in;

   logic                  fire;
   logic                  active;
   logic [TOTAL_BITS-1:0] total;
   logic [ACC_BITS-1:0]   acc;
   logic [BYTE_BITS-1:0]  byte0, byte1;
   logic [BYTE_BITS-1:0]  pmask;
   logic [3:0]            flush_sh;

   assign fire       = s1_valid_ff && space;
   assign take_ready = !s1_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pbits_ff    <= '0;
         pcount_ff   <= '0;
      end else begin
         if (take_ready) begin
            s1_valid_ff <= take;
         end
         if (fire) begin
            pbits_ff  <= pbits_in;
            pcount_ff <= pcount_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_ready) begin
         s1_flush_ff <= take_flush;
      end
   end

   assign active   = entry.hit && (entry.len != '0);
   assign total    = TOTAL_BITS'(pcount_ff) + TOTAL_BITS'(entry.len);
   assign acc      = (ACC_BITS'(pbits_ff) << entry.len) | ACC_BITS'(entry.code);
   assign byte0    = BYTE_BITS'(acc >> (total - TOTAL_BITS'(BYTE_BITS)));
   assign byte1    = BYTE_BITS'(acc >> (total - TOTAL_BITS'(2 * BYTE_BITS)));
   assign pmask    = (BYTE_BITS'(1) << total[TAIL_BITS-1:0]) - BYTE_BITS'(1);
   assign flush_sh = 4'(BYTE_BITS) - {1'b0, pcount_ff};

   always_comb begin
      push      = '0;
      pbits_in  = pbits_ff;
      pcount_in = pcount_ff;
      if (s1_flush_ff) begin
         push.count   = 2'd1;
         push.r0.last = 1'b1;
         if (pcount_ff != '0) begin
            push.r0.out_byte   = BYTE_BITS'(BYTE_BITS'(pbits_ff) << flush_sh);
            push.r0.byte_valid = 1'b1;
            push.r0.tail_bits  = pcount_ff;
         end
         pbits_in  = '0;
         pcount_in = '0;
      end else if (active) begin
         pcount_in = total[TAIL_BITS-1:0];
         pbits_in  = acc[PEND_BITS-1:0] & pmask[PEND_BITS-1:0];
         if (total >= TOTAL_BITS'(2 * BYTE_BITS)) begin
            push.count         = 2'd2;
            push.r0.out_byte   = byte0;
            push.r0.byte_valid = 1'b1;
            push.r1.out_byte   = byte1;
            push.r1.byte_valid = 1'b1;
            push.r1.last       = 1'b1;
         end else if (total >= TOTAL_BITS'(BYTE_BITS)) begin
            push.count         = 2'd1;
            push.r0.out_byte   = byte0;
            push.r0.byte_valid = 1'b1;
            push.r0.last       = 1'b1;
         end
      end
      if (!fire) begin
         push.count = 2'd0;
      end
   end

endmodule

// ===== hdl/hcbp_out_fifo.sv =====
// Result queue: takes up to two result items a cycle, hands out one while rsp_ready is high.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  hcbp_pkg::push_type     push,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output hcbp_pkg::rsp_item_type rsp_item,
   output logic                   space
);
   import hcbp_pkg::*;

   rsp_item_type      slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              pop;

   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_item  = slot_ff[rd_ptr_ff];
   assign space     = count_ff <= CNT_W'(FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push.count);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_ff + CNT_W'(push.count) - CNT_W'(pop);
      end
   end

endmodule

// ===== hdl/huffman_code_bit_packer.sv =====
// Top level of the code bit packer: code table, packing stage, result queue.
// Depends on hcbp_pkg, hcbp_code_table, hcbp_pack and hcbp_out_fifo.
//
//   channel | dir | tdata (low bit up)                      | tuser    | tlast
//   req_    | in  | symbol, code_bits, code_len, pad to 32  | req_type | -
//   rsp_    | out | out_byte, byte_valid, tail_bits, pad 16 | -        | last
//
// One item a cycle while req_tready is high; the table read is registered, and
// results pass the result queue; an encode item filling two bytes yields two.
// Reset clears all the table's valid bits together; no clearing pass.
// A four-item result queue decouples the sides; req_tready falls while the
// queue holds three or more items and the packing stage is occupied.
`timescale 1ns / 1ps

module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hcbp_pkg::REQ_DATA_W-1:0] req_tdata,  // symbol, code_bits, code_len
   input  logic [hcbp_pkg::REQ_USER_W-1:0] req_tuser,  // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hcbp_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_byte, byte_valid, tail_bits
   output logic                            rsp_tlast
);
   import hcbp_pkg::*;

   logic                   accept;
   logic                   load_en, encode_en, flush_en;
   logic [SYMBOL_BITS-1:0] symbol;
   logic [CODE_BITS-1:0]   code_bits;
   logic [LEN_BITS-1:0]    code_len;
   entry_type              entry;
   push_type               push;
   rsp_item_type           rsp_item;
   logic                   space;

   assign accept    = req_tvalid && req_tready;
   assign symbol    = req_tdata[SYMBOL_BITS-1:0];
   assign code_bits = req_tdata[SYMBOL_BITS+CODE_BITS-1:SYMBOL_BITS];
   assign code_len  = req_tdata[SYMBOL_BITS+CODE_BITS+LEN_BITS-1:SYMBOL_BITS+CODE_BITS];
   assign load_en   = accept && (req_tuser == REQ_LOAD);
   assign encode_en = accept && (req_tuser == REQ_ENCODE);
   assign flush_en  = accept && (req_tuser == REQ_FLUSH);

   hcbp_code_table #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .load_en   (load_en),
      .encode_en (encode_en),
      .symbol    (symbol),
      .code_bits (code_bits),
      .code_len  (code_len),
      .entry     (entry)
   );

   hcbp_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .take       (encode_en || flush_en),
      .take_flush (flush_en),
      .entry      (entry),
      .space      (space),
      .take_ready (req_tready),
      .push       (push)
   );

   hcbp_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_item  (rsp_item),
      .space     (space)
   );

   assign rsp_tdata = {(RSP_DATA_W - BYTE_BITS - 1 - TAIL_BITS)'(0),
                       rsp_item.tail_bits, rsp_item.byte_valid, rsp_item.out_byte};
   assign rsp_tlast = rsp_item.last;

endmodule

// ===== hdl/hcbp_checker.sv =====
// Port-level checks on the packer's result channel, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer_defines.svh.
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_defines.svh"

module hcbp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hcbp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import hcbp_pkg::*;

   `HCBP_ASSERT_NOW(a_empty_flush, rsp_tvalid && !rsp_tdata[8], rsp_tlast && rsp_tdata[11:9] == 3'd0 && rsp_tdata[7:0] == 8'd0, "empty item must be a bare flush")
   `HCBP_ASSERT_NOW(a_tail_last, rsp_tvalid && rsp_tdata[11:9] != 3'd0, rsp_tlast && rsp_tdata[8], "tail item must be valid and last")
   `HCBP_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:12] == '0, "padding bits set")
   `HCBP_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled item changed")
   `HCBP_ASSERT_ALWAYS_NEXT(a_reset_idle, reset, !rsp_tvalid, "result after reset")

endmodule

bind huffman_code_bit_packer hcbp_checker u_checker (.*);

// ===== tb/sv/huffman_code_bit_packer_tb.sv =====
// Self-checking testbench for huffman_code_bit_packer: loads, encodes and flushes
// are streamed in with random gaps, and results are checked against an in-bench model.
// Depends on hcbp_pkg and the huffman_code_bit_packer RTL.
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;
   import hcbp_pkg::*;

   localparam logic [REQ_USER_W-1:0] REQ_NONE = 2'd3;
   localparam int MAX_LEN   = DEF_MAX_CODE_LEN < CODE_BITS ? DEF_MAX_CODE_LEN : CODE_BITS;
   localparam int NUM_ITEMS = 500;
   localparam int LIMIT     = 400000;
   localparam int DRAIN     = 20;

   typedef struct {
      logic [REQ_USER_W-1:0]  kind;
      logic [SYMBOL_BITS-1:0] sym;
      logic [CODE_BITS-1:0]   code;
      logic [LEN_BITS-1:0]    len;
   } code_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // symbol, code_bits, code_len
   logic [REQ_USER_W-1:0] req_tuser = '0;  // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // out_byte, byte_valid, tail_bits
   logic                  rsp_tlast;

   code_req_type req_backlog[$];
   rsp_item_type expected_bytes[$];

   logic [CODE_BITS-1:0] entry_code[256];
   logic [LEN_BITS-1:0]  entry_len[256];
   logic [PEND_BITS-1:0] held_bits;
   int                   held_count;

   logic req_taken = 1'b0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   bit   req_steady = 1'b0;
   bit   rsp_steady = 1'b0;
   int   errors = 0;
   int   cycle_count = 0;

   huffman_code_bit_packer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic void add_req(logic [REQ_USER_W-1:0] kind, logic [7:0] sym,
                                   logic [15:0] code, logic [4:0] len);
      code_req_type it;
      it.kind = kind;
      it.sym  = sym;
      it.code = code;
      it.len  = len;
      req_backlog.push_back(it);
   endfunction

   // table update or bit packing for one accepted item; pushes the bytes it yields
   function automatic void pack_request(code_req_type it);
      logic [31:0] acc;
      int          total;
      int          l;
      case (it.kind)
         REQ_LOAD: begin
            l = (it.len > MAX_LEN) ? MAX_LEN : int'(it.len);
            entry_len[it.sym]  = LEN_BITS'(l);
            entry_code[it.sym] = CODE_BITS'(32'(it.code) & ((32'd1 << l) - 32'd1));
         end
         REQ_ENCODE: begin
            l = int'(entry_len[it.sym]);
            if (l != 0) begin
               acc   = (32'(held_bits) << l) | 32'(entry_code[it.sym]);
               total = held_count + l;
               while (total >= BYTE_BITS) begin
                  expected_bytes.push_back(rsp_item_type'{
                     out_byte: BYTE_BITS'(acc >> (total - BYTE_BITS)), byte_valid: 1'b1,
                     tail_bits: 3'd0, last: (total - BYTE_BITS) < BYTE_BITS});
                  total -= BYTE_BITS;
               end
               held_count = total;
               held_bits  = PEND_BITS'(acc & ((32'd1 << total) - 32'd1));
            end
         end
         REQ_FLUSH: begin
            if (held_count == 0)
               expected_bytes.push_back(rsp_item_type'{
                  out_byte: 8'd0, byte_valid: 1'b0, tail_bits: 3'd0, last: 1'b1});
            else
               expected_bytes.push_back(rsp_item_type'{
                  out_byte: BYTE_BITS'(32'(held_bits) << (BYTE_BITS - held_count)),
                  byte_valid: 1'b1, tail_bits: TAIL_BITS'(held_count), last: 1'b1});
            held_bits  = '0;
            held_count = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string name, logic [31:0] exp_val,
                                         logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t %s expected %0h actual %0h", $time, name, exp_val, act_val);
         errors++;
      end
   endfunction

   // request driver
   always @(negedge clock) begin
      code_req_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (req_backlog.size() > 0) begin
            it = req_backlog.pop_front();
            req_tdata  <= {3'b000, it.len, it.code, it.sym};
            req_tuser  <= it.kind;
            req_tvalid <= 1'b1;
            if ($urandom_range(49) == 0) req_steady = !req_steady;
            req_gap = req_steady ? 0 : gap_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(49) == 0) rsp_steady = !rsp_steady;
         if (!rsp_steady && $urandom_range(99) < 30) rsp_stall = gap_len();
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      code_req_type it;
      rsp_item_type want;
      if (reset) begin
         req_taken <= 1'b0;
         for (int i = 0; i < 256; i++) begin
            entry_code[i] = '0;
            entry_len[i]  = '0;
         end
         held_bits  = '0;
         held_count = 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            it.sym  = req_tdata[7:0];
            it.code = req_tdata[23:8];
            it.len  = req_tdata[28:24];
            it.kind = req_tuser;
            pack_request(it);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t unexpected result: expected none actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               compare_field("out_byte", 32'(want.out_byte), 32'(rsp_tdata[7:0]));
               compare_field("byte_valid", 32'(want.byte_valid), 32'(rsp_tdata[8]));
               compare_field("tail_bits", 32'(want.tail_bits), 32'(rsp_tdata[11:9]));
               compare_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("huffman_code_bit_packer: mismatch");
      $finish;
   end

   initial begin
      int          count;
      int          k;
      int          r;
      logic [7:0]  sym;
      logic [4:0]  len;
      logic [1:0]  kind;
      logic [7:0]  loaded[$];

      // directed: extremes, masking, saturation, unused entries, empty flush
      add_req(REQ_LOAD, 8'd0, 16'hffff, 5'd16);
      add_req(REQ_LOAD, 8'd255, 16'hffff, 5'd1);
      add_req(REQ_LOAD, 8'd128, 16'haaaa, 5'd31);
      add_req(REQ_LOAD, 8'd7, 16'h1234, 5'd0);
      add_req(REQ_LOAD, 8'd1, 16'h005a, 5'd8);
      add_req(REQ_LOAD, 8'd2, 16'h0003, 5'd3);
      add_req(REQ_ENCODE, 8'd0, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd255, 16'hffff, 5'd31);
      add_req(REQ_ENCODE, 8'd2, 16'h0000, 5'd0);
      add_req(REQ_FLUSH, 8'd0, 16'h0000, 5'd0);
      add_req(REQ_FLUSH, 8'hff, 16'hffff, 5'd31);
      add_req(REQ_ENCODE, 8'd7, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd200, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd1, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd255, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd128, 16'h0000, 5'd0);
      add_req(REQ_NONE, 8'd0, 16'hffff, 5'd16);
      add_req(REQ_FLUSH, 8'd0, 16'h0000, 5'd0);
      add_req(REQ_LOAD, 8'd255, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd255, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd2, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd0, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd2, 16'h0000, 5'd0);
      add_req(REQ_ENCODE, 8'd2, 16'h0000, 5'd0);
      add_req(REQ_FLUSH, 8'd0, 16'h0000, 5'd0);

      // random: table loads, encode runs over loaded symbols, some noise
      count = 0;
      while (count < NUM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 15 || loaded.size() < 4) begin
            k = $urandom_range(12, 3);
            repeat (k) begin
               sym = 8'($urandom_range(255));
               r = $urandom_range(99);
               if (r < 80) len = 5'($urandom_range(MAX_LEN, 1));
               else if (r < 90) len = 5'd0;
               else len = 5'($urandom_range(31, MAX_LEN + 1));
               add_req(REQ_LOAD, sym, 16'($urandom), len);
               if (len != 0) loaded.push_back(sym);
               count++;
            end
         end else if (r < 85) begin
            k = $urandom_range(30, 3);
            repeat (k) begin
               if ($urandom_range(9) != 0)
                  sym = loaded[$urandom_range(loaded.size() - 1)];
               else
                  sym = 8'($urandom_range(255));
               add_req(REQ_ENCODE, sym, 16'($urandom), 5'($urandom));
               count++;
            end
            if ($urandom_range(4) != 0) begin
               add_req(REQ_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom));
               count++;
            end
         end else begin
            kind = 2'($urandom_range(3));
            add_req(kind, 8'($urandom), 16'($urandom), 5'($urandom));
            if (kind != REQ_NONE) count++;
         end
      end
      add_req(REQ_FLUSH, 8'd0, 16'h0000, 5'd0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);

      if (errors == 0 && expected_bytes.size() == 0)
         $display("huffman_code_bit_packer: match");
      else
         $display("huffman_code_bit_packer: mismatch");
      $finish;
   end

endmodule
